### src/rsi_pkg.sv
package rsi_pkg;

   // Default configuration of the datapath
   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 12;

   // Fixed field widths of the request and response
   localparam int FIELD_W  = 24;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 32;

   // Distance clamp limits
   localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

   typedef struct packed {
      logic signed [FIELD_W-1:0] eye_x;
      logic signed [FIELD_W-1:0] eye_y;
      logic signed [FIELD_W-1:0] eye_z;
      logic signed [FIELD_W-1:0] dir_x;
      logic signed [FIELD_W-1:0] dir_y;
      logic signed [FIELD_W-1:0] dir_z;
      logic [RADIUS_W-1:0]       sphere_radius;
   } rsi_req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DIST_W-1:0] distance;
      logic                     zero_direction;
      logic                     saturated;
   } rsi_rsp_type;

   // Per-request flags that ride along the pipeline
   typedef struct packed {
      logic zero_dir;
      logic miss;
   } rsi_ctrl_type;

   // Distance reported for a miss: -1.0 in the output format
   function automatic logic [DIST_W-1:0] neg_one(input int frac);
      return DIST_W'(-(64'sd1 <<< frac));
   endfunction

endpackage

### src/ray_sphere_intersect_top.sv
// Ray / sphere intersection by the quadratic formula in exact fixed point. Each request
// carries a ray origin relative to the sphere centre, a ray direction and a radius; each
// produces one response with the hit flag, the chosen root t (Q20.12, saturated, -1.0 on
// a miss), a zero-direction flag and a saturation flag. A new request is taken every
// cycle unless the pipeline is held. The pipeline runs through the coefficient and
// discriminant arithmetic, the pipelined square root, the numerator register, the two
// parallel pipelined dividers and the output register. The whole pipeline holds while
// a response waits on rsp_stall.
module ray_sphere_intersect_top #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rsi_pkg::rsi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsi_pkg::rsi_rsp_type rsp_data
);
   import rsi_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int MW     = 2 * W;
   localparam int DW     = 4 * W + 1;
   localparam int ROOT_W = 2 * W + 1;
   localparam int NW     = 2 * W + 2;
   localparam int NSW    = NW + 1;
   localparam int QW     = NW + FRAC_BITS;
   localparam int SQ_SW  = $bits(rsi_ctrl_type) + 1 + 2 * MW;
   localparam int HI_SW  = $bits(rsi_ctrl_type) + 1;
   localparam logic [DIST_W-1:0] NEG_ONE = neg_one(FRAC_BITS);

   logic adv;

   logic          cf_valid, cf_bneg;
   rsi_ctrl_type  cf_ctrl;
   logic [DW-1:0] cf_disc;
   logic [MW-1:0] cf_bm, cf_a;

   logic              sq_valid, sq_bneg;
   logic [ROOT_W-1:0] sq_root;
   logic [SQ_SW-1:0]  sq_side;
   rsi_ctrl_type      sq_ctrl;
   logic [MW-1:0]     sq_bm, sq_a;

   logic signed [NSW-1:0] nb, s_ext, lo_num, hi_num;
   logic [NW-1:0]         lo_mag_in, hi_mag_in, lo_mag_ff, hi_mag_ff;
   logic                  lo_neg_ff, hi_neg_ff, nm_valid_ff;
   logic [MW-1:0]         nm_a_ff;
   rsi_ctrl_type          nm_ctrl_ff;

   logic             dl_valid, dh_valid, dl_neg, dh_neg;
   logic [QW-1:0]    dl_quo, dh_quo;
   logic [HI_SW-1:0] dh_side;
   rsi_ctrl_type     dh_ctrl;

   // Advance whenever the output slot is free or being emptied
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   rsi_coef #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (cf_valid),
      .out_ctrl  (cf_ctrl),
      .out_disc  (cf_disc),
      .out_bm    (cf_bm),
      .out_bneg  (cf_bneg),
      .out_a     (cf_a)
   );

   rsi_sqrt #(
      .RAD_W  (DW),
      .ROOT_W (ROOT_W),
      .SIDE_W (SQ_SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cf_valid),
      .in_rad    (cf_disc),
      .in_side   ({cf_ctrl, cf_bneg, cf_bm, cf_a}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_ctrl, sq_bneg, sq_bm, sq_a} = sq_side;

   // Form -h - s and -h + s as sign and magnitude
   always_comb begin
      nb        = sq_bneg ? signed'(NSW'(sq_bm)) : -signed'(NSW'(sq_bm));
      s_ext     = signed'(NSW'(sq_root));
      lo_num    = nb - s_ext;
      hi_num    = nb + s_ext;
      lo_mag_in = lo_num[NSW-1] ? NW'(-lo_num) : NW'(lo_num);
      hi_mag_in = hi_num[NSW-1] ? NW'(-hi_num) : NW'(hi_num);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff <= 1'b0;
      end else if (adv) begin
         nm_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_mag_ff  <= lo_mag_in;
         hi_mag_ff  <= hi_mag_in;
         lo_neg_ff  <= lo_num[NSW-1];
         hi_neg_ff  <= hi_num[NSW-1];
         nm_a_ff    <= sq_a;
         nm_ctrl_ff <= sq_ctrl;
      end
   end

   rsi_div #(
      .NUM_W  (QW),
      .DEN_W  (MW),
      .SIDE_W (1)
   ) u_div_lo (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (nm_valid_ff),
      .in_num    ({lo_mag_ff, {FRAC_BITS{1'b0}}}),
      .in_den    (nm_a_ff),
      .in_side   (lo_neg_ff),
      .out_valid (dl_valid),
      .out_quo   (dl_quo),
      .out_side  (dl_neg)
   );

   rsi_div #(
      .NUM_W  (QW),
      .DEN_W  (MW),
      .SIDE_W (HI_SW)
   ) u_div_hi (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (nm_valid_ff),
      .in_num    ({hi_mag_ff, {FRAC_BITS{1'b0}}}),
      .in_den    (nm_a_ff),
      .in_side   ({nm_ctrl_ff, hi_neg_ff}),
      .out_valid (dh_valid),
      .out_quo   (dh_quo),
      .out_side  (dh_side)
   );

   assign {dh_ctrl, dh_neg} = dh_side;

   rsi_pick #(
      .QW        (QW),
      .FRAC_BITS (FRAC_BITS)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dh_valid),
      .in_ctrl   (dh_ctrl),
      .in_q_lo   (dl_quo),
      .in_neg_lo (dl_neg),
      .in_q_hi   (dh_quo),
      .in_neg_hi (dh_neg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dl_valid == dh_valid)
      else $error("root dividers out of step");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with free output");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.distance == NEG_ONE && !rsp_data.saturated))
      else $error("miss without -1.0 distance");

   a_hit_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.zero_direction))
      else $error("hit reported for zero direction");
`endif

endmodule

### src/rsi_coef.sv
module rsi_coef #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  rsi_pkg::rsi_req_type       in_req,
   output logic                       out_valid,
   output rsi_pkg::rsi_ctrl_type      out_ctrl,
   output logic [4*COORD_WIDTH:0]     out_disc,
   output logic [2*COORD_WIDTH-1:0]   out_bm,
   output logic                       out_bneg,
   output logic [2*COORD_WIDTH-1:0]   out_a
);
   import rsi_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int MW  = 2 * W;
   localparam int XW  = (W > FIELD_W) ? W : FIELD_W;
   localparam int XR  = (W - 1 > RADIUS_W) ? W - 1 : RADIUS_W;
   localparam int NST = 7;

   logic [NST-1:0] valid_ff;

   // Stage 1: magnitudes and signs
   logic [FIELD_W-1:0] eye_raw [3];
   logic [FIELD_W-1:0] dir_raw [3];
   logic [W-1:0]       eye_sv [3];
   logic [W-1:0]       dir_sv [3];
   logic [XW-1:0]      eye_ext [3];
   logic [XW-1:0]      dir_ext [3];
   logic [XR-1:0]      rad_ext;
   logic [W-1:0]       mo_in [3];
   logic [W-1:0]       md_in [3];
   logic [2:0]         sx_in;
   logic [W-1:0]       mo_ff [3];
   logic [W-1:0]       md_ff [3];
   logic [2:0]         sx_ff;
   logic [W-2:0]       r_ff;

   // Stage 2: products
   logic [MW-1:0] pa_ff [3];
   logic [MW-1:0] po_ff [3];
   logic [MW-1:0] pd_ff [3];
   logic [2:0]    sx2_ff;
   logic [MW-3:0] r2_ff;

   // Stage 3: sums
   logic [MW-1:0] a3_ff, o2_ff, pos_ff, neg_ff;
   logic [MW-3:0] r23_ff;

   // Stage 4: coefficient magnitudes
   logic [MW-1:0] bm4_ff, cm4_ff, a4_ff;
   logic          bneg4_ff, cneg4_ff, zd4_ff;

   // Stage 5: partial products
   logic [MW-1:0] bhh_ff, bhl_ff, bll_ff, chh_ff, chl_ff, clh_ff, cll_ff;
   logic [MW-1:0] bm5_ff, a5_ff;
   logic          bneg5_ff, cneg5_ff, zd5_ff;

   // Stage 6: full squares
   logic [2*MW-1:0] b2_in, ac_in, b2_ff, ac_ff;
   logic [MW:0]     midb, midc;
   logic [MW-1:0]   bm6_ff, a6_ff;
   logic            bneg6_ff, cneg6_ff, zd6_ff;

   // Stage 7: discriminant
   logic [2*MW:0] disc_in, disc_ff;
   logic          miss_in, miss_ff;
   logic [MW-1:0] bm7_ff, a7_ff;
   logic          bneg7_ff, zd7_ff;

   // Unpack the request and take the low coordinate bits
   always_comb begin
      eye_raw[0] = in_req.eye_x;
      eye_raw[1] = in_req.eye_y;
      eye_raw[2] = in_req.eye_z;
      dir_raw[0] = in_req.dir_x;
      dir_raw[1] = in_req.dir_y;
      dir_raw[2] = in_req.dir_z;
      rad_ext    = XR'(in_req.sphere_radius);
      for (int i = 0; i < 3; i++) begin
         eye_ext[i] = XW'(eye_raw[i]);
         dir_ext[i] = XW'(dir_raw[i]);
         eye_sv[i]  = eye_ext[i][W-1:0];
         dir_sv[i]  = dir_ext[i][W-1:0];
         mo_in[i]   = eye_sv[i][W-1] ? (~eye_sv[i] + W'(1)) : eye_sv[i];
         md_in[i]   = dir_sv[i][W-1] ? (~dir_sv[i] + W'(1)) : dir_sv[i];
         sx_in[i]   = eye_sv[i][W-1] ^ dir_sv[i][W-1];
      end
   end

   // Partial product sums for the squares
   always_comb begin
      midb  = (MW+1)'(bhl_ff) << 1;
      midc  = (MW+1)'(chl_ff) + (MW+1)'(clh_ff);
      b2_in = {bhh_ff, bll_ff} + ((2*MW)'(midb) << W);
      ac_in = {chh_ff, cll_ff} + ((2*MW)'(midc) << W);
   end

   // Discriminant h^2 - a*c, sign folded in by the sign of c
   always_comb begin
      miss_in = !cneg6_ff && (b2_ff < ac_ff);
      if (cneg6_ff) begin
         disc_in = (2*MW+1)'(b2_ff) + (2*MW+1)'(ac_ff);
      end else begin
         disc_in = (2*MW+1)'(b2_ff) - (2*MW+1)'(ac_ff);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], in_valid};
      end
   end

   // Advance the data path
   always_ff @(posedge clock) begin
      if (adv) begin
         mo_ff  <= mo_in;
         md_ff  <= md_in;
         sx_ff  <= sx_in;
         r_ff   <= rad_ext[W-2:0];

         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= md_ff[i] * md_ff[i];
            po_ff[i] <= mo_ff[i] * mo_ff[i];
            pd_ff[i] <= mo_ff[i] * md_ff[i];
         end
         sx2_ff <= sx_ff;
         r2_ff  <= r_ff * r_ff;

         a3_ff  <= pa_ff[0] + pa_ff[1] + pa_ff[2];
         o2_ff  <= po_ff[0] + po_ff[1] + po_ff[2];
         pos_ff <= (sx2_ff[0] ? '0 : pd_ff[0]) + (sx2_ff[1] ? '0 : pd_ff[1])
                 + (sx2_ff[2] ? '0 : pd_ff[2]);
         neg_ff <= (sx2_ff[0] ? pd_ff[0] : '0) + (sx2_ff[1] ? pd_ff[1] : '0)
                 + (sx2_ff[2] ? pd_ff[2] : '0);
         r23_ff <= r2_ff;

         bneg4_ff <= neg_ff > pos_ff;
         bm4_ff   <= (neg_ff > pos_ff) ? neg_ff - pos_ff : pos_ff - neg_ff;
         cneg4_ff <= MW'(r23_ff) > o2_ff;
         cm4_ff   <= (MW'(r23_ff) > o2_ff) ? MW'(r23_ff) - o2_ff : o2_ff - MW'(r23_ff);
         a4_ff    <= a3_ff;
         zd4_ff   <= a3_ff == '0;

         bhh_ff   <= bm4_ff[MW-1:W] * bm4_ff[MW-1:W];
         bhl_ff   <= bm4_ff[MW-1:W] * bm4_ff[W-1:0];
         bll_ff   <= bm4_ff[W-1:0] * bm4_ff[W-1:0];
         chh_ff   <= a4_ff[MW-1:W] * cm4_ff[MW-1:W];
         chl_ff   <= a4_ff[MW-1:W] * cm4_ff[W-1:0];
         clh_ff   <= a4_ff[W-1:0] * cm4_ff[MW-1:W];
         cll_ff   <= a4_ff[W-1:0] * cm4_ff[W-1:0];
         bm5_ff   <= bm4_ff;
         a5_ff    <= a4_ff;
         bneg5_ff <= bneg4_ff;
         cneg5_ff <= cneg4_ff;
         zd5_ff   <= zd4_ff;

         b2_ff    <= b2_in;
         ac_ff    <= ac_in;
         bm6_ff   <= bm5_ff;
         a6_ff    <= a5_ff;
         bneg6_ff <= bneg5_ff;
         cneg6_ff <= cneg5_ff;
         zd6_ff   <= zd5_ff;

         disc_ff  <= disc_in;
         miss_ff  <= miss_in;
         bm7_ff   <= bm6_ff;
         a7_ff    <= a6_ff;
         bneg7_ff <= bneg6_ff;
         zd7_ff   <= zd6_ff;
      end
   end

   assign out_valid         = valid_ff[NST-1];
   assign out_ctrl.zero_dir = zd7_ff;
   assign out_ctrl.miss     = miss_ff;
   assign out_disc          = disc_ff;
   assign out_bm            = bm7_ff;
   assign out_bneg          = bneg7_ff;
   assign out_a             = a7_ff;

endmodule

### src/rsi_sqrt.sv
module rsi_sqrt #(
   parameter int RAD_W  = 4 * rsi_pkg::COORD_WIDTH_DEF + 1,
   parameter int ROOT_W = 2 * rsi_pkg::COORD_WIDTH_DEF + 1,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);
   localparam int RW   = ROOT_W + 2;
   localparam int RAD2 = 2 * ROOT_W;

   logic [ROOT_W-1:0] valid_ff;
   logic [RW-1:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD2-1:0]   rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   // One root bit per stage, restoring digit recurrence
   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic [RW-1:0]     rem_src, cur, trial, rem_in;
      logic [ROOT_W-1:0] root_src, root_in;
      logic [RAD2-1:0]   rad_src;
      logic [SIDE_W-1:0] side_src;
      logic              valid_src, ge;

      if (g == 0) begin : g_first
         assign rem_src   = '0;
         assign root_src  = '0;
         assign rad_src   = RAD2'(in_rad);
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[g-1];
         assign root_src  = root_ff[g-1];
         assign rad_src   = rad_ff[g-1];
         assign side_src  = side_ff[g-1];
         assign valid_src = valid_ff[g-1];
      end

      always_comb begin
         cur     = {rem_src[ROOT_W-1:0], rad_src[RAD2-1 -: 2]};
         trial   = (RW'(root_src) << 2) | RW'(1);
         ge      = cur >= trial;
         rem_in  = ge ? cur - trial : cur;
         root_in = {root_src[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            rad_ff[g]  <= rad_src << 2;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

### src/rsi_div.sv
module rsi_div #(
   parameter int NUM_W  = 2 * rsi_pkg::COORD_WIDTH_DEF + 2 + rsi_pkg::FRAC_BITS_DEF,
   parameter int DEN_W  = 2 * rsi_pkg::COORD_WIDTH_DEF,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   localparam int RW = DEN_W + 1;

   logic [NUM_W-1:0]  valid_ff;
   logic [RW-1:0]     rem_ff  [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   // One quotient bit per stage; dividend bits shift out as quotient bits shift in
   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic [RW-1:0]     rem_src, cur, rem_in;
      logic [NUM_W-1:0]  nq_src, nq_in;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic              valid_src, ge;

      if (g == 0) begin : g_first
         assign rem_src   = '0;
         assign nq_src    = in_num;
         assign den_src   = in_den;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[g-1];
         assign nq_src    = nq_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign side_src  = side_ff[g-1];
         assign valid_src = valid_ff[g-1];
      end

      always_comb begin
         cur    = {rem_src[DEN_W-1:0], nq_src[NUM_W-1]};
         ge     = cur >= RW'(den_src);
         rem_in = ge ? cur - RW'(den_src) : cur;
         nq_in  = {nq_src[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= rem_in;
            nq_ff[g]   <= nq_in;
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

### src/rsi_pick.sv
module rsi_pick #(
   parameter int QW        = 2 * rsi_pkg::COORD_WIDTH_DEF + 2 + rsi_pkg::FRAC_BITS_DEF,
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  rsi_pkg::rsi_ctrl_type in_ctrl,
   input  logic [QW-1:0]         in_q_lo,
   input  logic                  in_neg_lo,
   input  logic [QW-1:0]         in_q_hi,
   input  logic                  in_neg_hi,
   output logic                  rsp_valid,
   output rsi_pkg::rsi_rsp_type  rsp_data
);
   import rsi_pkg::*;

   localparam logic [DIST_W-1:0] NEG_ONE = neg_one(FRAC_BITS);

   logic                rsp_valid_ff;
   rsi_rsp_type         rsp_ff, rsp_in;
   logic [DIST_W:0]     lo_c, hi_c, pick_c;
   logic                lo_pos;

   // Sign the quotient and clamp it to the distance range; top bit flags a clamp
   function automatic logic [DIST_W:0] clamp(input logic [QW-1:0] q, input logic neg);
      logic over_pos, over_neg;
      logic [DIST_W-1:0] low;
      over_pos = q[QW-1:DIST_W-1] != '0;
      over_neg = over_pos && !((q[QW-1:DIST_W-1] == (QW-DIST_W+1)'(1))
                               && (q[DIST_W-2:0] == '0));
      low = q[DIST_W-1:0];
      if (!neg) begin
         return over_pos ? {1'b1, DIST_MAX} : {1'b0, low};
      end else begin
         return over_neg ? {1'b1, DIST_MIN} : {1'b0, -low};
      end
   endfunction

   // Choose the nearer root when it lies ahead, else the farther one
   always_comb begin
      lo_c   = clamp(in_q_lo, in_neg_lo);
      hi_c   = clamp(in_q_hi, in_neg_hi);
      lo_pos = !in_neg_lo && (in_q_lo != '0);
      pick_c = lo_pos ? lo_c : hi_c;
      priority if (in_ctrl.zero_dir) begin
         rsp_in.hit            = 1'b0;
         rsp_in.distance       = NEG_ONE;
         rsp_in.zero_direction = 1'b1;
         rsp_in.saturated      = 1'b0;
      end else if (in_ctrl.miss) begin
         rsp_in.hit            = 1'b0;
         rsp_in.distance       = NEG_ONE;
         rsp_in.zero_direction = 1'b0;
         rsp_in.saturated      = 1'b0;
      end else begin
         rsp_in.hit            = 1'b1;
         rsp_in.distance       = pick_c[DIST_W-1:0];
         rsp_in.zero_direction = 1'b0;
         rsp_in.saturated      = pick_c[DIST_W];
      end
   end

   // Hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### test/rsi_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each response from the accepted request and
// compares field by field in order.
module rsi_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  rsi_pkg::rsi_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsi_pkg::rsi_rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   rays_in_flight
);
   import rsi_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam logic [DIST_W-1:0] MISS_DIST = -(32'sd1 <<< FRAC);

   typedef struct packed {
      logic [DIST_W-1:0] val;
      logic              sat;
      logic              pos;
   } root_type;

   rsi_rsp_type expected_hits[$];

   initial mismatch_count = 0;
   assign rays_in_flight = expected_hits.size();

   // Floor of the exact square root of a nonnegative 128-bit value
   function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'b0, cand} * {64'b0, cand} <= v) res = cand;
      end
      return res;
   endfunction

   // Scale a root numerator by 2^FRAC, divide by a truncating the magnitude, clamp
   function automatic root_type scale_root(input logic signed [127:0] num,
                                           input logic [127:0] a);
      root_type r;
      logic        neg;
      logic [127:0] mag;
      logic [127:0] quo;
      neg = num < 0;
      mag = neg ? 128'(-num) : 128'(num);
      mag = mag << FRAC;
      quo = mag / a;
      r.sat = 1'b0;
      r.pos = !neg && quo != 0;
      if (!neg) begin
         if (quo > 128'h7FFF_FFFF) begin
            r.val = DIST_MAX;
            r.sat = 1'b1;
         end else begin
            r.val = quo[31:0];
         end
      end else begin
         if (quo > 128'h8000_0000) begin
            r.val = DIST_MIN;
            r.sat = 1'b1;
         end else begin
            r.val = -quo[31:0];
         end
      end
      return r;
   endfunction

   // Intersect one ray with the sphere
   function automatic rsi_rsp_type trace_sphere(input rsi_req_type q);
      rsi_rsp_type p;
      longint ox, oy, oz, dx, dy, dz, rad, a, h, c;
      logic signed [127:0] hw, aw, cw, disc, sw;
      root_type near_t, far_t, pick;
      p.hit = 1'b0;
      p.distance = MISS_DIST;
      p.zero_direction = 1'b0;
      p.saturated = 1'b0;
      ox = longint'(q.eye_x);
      oy = longint'(q.eye_y);
      oz = longint'(q.eye_z);
      dx = longint'(q.dir_x);
      dy = longint'(q.dir_y);
      dz = longint'(q.dir_z);
      rad = longint'(q.sphere_radius);
      a = dx * dx + dy * dy + dz * dz;
      if (a == 0) begin
         p.zero_direction = 1'b1;
         return p;
      end
      h = ox * dx + oy * dy + oz * dz;
      c = ox * ox + oy * oy + oz * oz - rad * rad;
      hw = h;
      aw = a;
      cw = c;
      disc = hw * hw - aw * cw;
      if (disc < 0) return p;
      if (disc == 0) begin
         pick = scale_root(-hw, aw);
      end else begin
         sw = {64'b0, floor_sqrt(disc)};
         near_t = scale_root(-hw - sw, aw);
         far_t = scale_root(-hw + sw, aw);
         pick = near_t.pos ? near_t : far_t;
      end
      p.hit = 1'b1;
      p.distance = pick.val;
      p.saturated = pick.sat;
      return p;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Queue a prediction per accepted request, check each accepted response
   always @(posedge clock) begin
      rsi_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_hits.push_back(trace_sphere(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               report("response with no request outstanding", 64'd1, 64'd0);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_data.hit !== want.hit) report("hit", rsp_data.hit, want.hit);
               if (rsp_data.distance !== want.distance)
                  report("distance", rsp_data.distance, want.distance);
               if (rsp_data.zero_direction !== want.zero_direction)
                  report("zero_direction", rsp_data.zero_direction, want.zero_direction);
               if (rsp_data.saturated !== want.saturated)
                  report("saturated", rsp_data.saturated, want.saturated);
            end
         end
      end
   end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rsi_pkg::*;

   localparam int RAY_COUNT   = 1800;
   localparam int DRAIN_WAIT  = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ONE         = 1 << FRAC_BITS_DEF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rsi_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsi_rsp_type rsp_data;
   int          mismatch_count;
   int          rays_in_flight;
   int          cycle_count = 0;
   logic        hold_rsp = 1'b0;

   always #1 clock = ~clock;

   ray_sphere_intersect_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   rsi_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .rays_in_flight(rays_in_flight)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stall responses on a changing pattern; hold off a long stretch on request
   initial begin
      int mode;
      int span;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            for (int i = 0; i < 400; i++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         for (int i = 0; i < span && !hold_rsp; i++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= (i % 5 < 3);
            endcase
            @(negedge clock);
         end
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_ray(input rsi_req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_rays(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      for (int i = 1; i < n; i++) @(negedge clock);
   endtask

   function automatic rsi_req_type make_ray(input int ex, ey, ez, dx, dy, dz, input int rad);
      rsi_req_type r;
      r.eye_x = FIELD_W'(ex);
      r.eye_y = FIELD_W'(ey);
      r.eye_z = FIELD_W'(ez);
      r.dir_x = FIELD_W'(dx);
      r.dir_y = FIELD_W'(dy);
      r.dir_z = FIELD_W'(dz);
      r.sphere_radius = RADIUS_W'(rad);
      return r;
   endfunction

   function automatic int pick_signed(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Random ray: wild bits, a ray aimed near a sphere of moderate size, or a tiny direction
   function automatic rsi_req_type random_ray();
      rsi_req_type r;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         r = make_ray(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom), int'($urandom), int'($urandom));
      end else if (kind < 9) begin
         r = make_ray(pick_signed(40 * ONE), pick_signed(40 * ONE), pick_signed(40 * ONE),
                      pick_signed(2 * ONE), pick_signed(2 * ONE), pick_signed(2 * ONE),
                      int'($urandom_range(0, 30 * ONE)));
      end else begin
         // tiny direction so the distance runs out of range
         r = make_ray(pick_signed(2000 * ONE), pick_signed(2000 * ONE), pick_signed(8),
                      pick_signed(3), pick_signed(3), pick_signed(3),
                      int'($urandom_range(0, 2100 * ONE)));
      end
      return r;
   endfunction

   rsi_req_type directed[$];

   initial begin
      int burst;
      logic held_off;
      held_off = 1'b0;
      for (int i = 0; i < 8; i++) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero direction, extremes, miss, tangent, inside, behind, out of range
      directed.push_back(make_ray(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, ONE));
      directed.push_back(make_ray(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                  8388607));
      directed.push_back(make_ray(-8388608, -8388608, -8388608, -8388608, -8388608,
                                  -8388608, 8388607));
      directed.push_back(make_ray(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                                  0));
      directed.push_back(make_ray(-8388608, 0, 0, 8388607, 0, 0, 8388607));
      directed.push_back(make_ray(-10 * ONE, 5 * ONE, 0, ONE, 0, 0, ONE));
      directed.push_back(make_ray(-10 * ONE, ONE, 0, ONE, 0, 0, ONE));
      directed.push_back(make_ray(-10 * ONE, 0, 0, ONE, 0, 0, 2 * ONE));
      directed.push_back(make_ray(0, 0, 0, 0, ONE, 0, 3 * ONE));
      directed.push_back(make_ray(0, 0, 10 * ONE, 0, 0, ONE, 2 * ONE));
      directed.push_back(make_ray(-8388608, 0, 0, 1, 0, 0, ONE));
      directed.push_back(make_ray(8388607, 0, 0, 1, 0, 0, ONE));
      directed.push_back(make_ray(0, 0, 0, 1, 0, 0, 8388607));
      directed.push_back(make_ray(-ONE, 0, 0, 8388607, 0, 0, ONE - 1));
      directed.push_back(make_ray(0, 0, 0, 0, 0, 1, 0));
      directed.push_back(make_ray(0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_ray(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                                  8388607));
      foreach (directed[i]) send_ray(directed[i]);

      // random rays in bursts with gaps; one long response hold-off midway
      for (int n = 0; n < RAY_COUNT; ) begin
         if (n >= 400 && !held_off) begin
            hold_rsp = 1'b1;
            held_off = 1'b1;
         end
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && n < RAY_COUNT; i++) begin
            send_ray(random_ray());
            n++;
         end
         if ($urandom_range(0, 2) != 0) pause_rays($urandom_range(1, 12));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (rays_in_flight != 0) @(posedge clock);
      for (int i = 0; i < DRAIN_WAIT; i++) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
